/* rtl/core/gcl_pkg.sv */
// ----------------------------------------------------------------------------
// gcl_pkg: shared types and constants for the glyph coverage lookup
// Item layouts, opcode and map-kind codes, descriptor record, ALU interface.
// ----------------------------------------------------------------------------
package gcl_pkg;

    // Default sizes, handed to the top level parameters
    localparam int MAX_MAPS_DEF        = 16;
    localparam int CODE_LIST_DEPTH_DEF = 4096;
    localparam int OFFSET_DEPTH_DEF    = 4096;

    // Fixed field widths
    localparam int CP_W     = 21;
    localparam int SPAN_W   = 16;
    localparam int TOTAL_W  = 16;
    localparam int BASE_W   = 12;
    localparam int ADDR_W   = 12;
    localparam int VALUE_W  = 16;
    localparam int IDX_W    = 4;
    localparam int MAP_ID_W = 4;
    localparam int CNT_W    = 5;
    localparam int ALU_W    = 22;
    localparam int IN_W     = 128;
    localparam int OUT_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // Input item opcodes (carried on tuser)
    typedef enum logic [1:0] {
        OP_WR_DESC = 2'd0,
        OP_WR_CODE = 2'd1,
        OP_WR_OFS  = 2'd2,
        OP_QUERY   = 2'd3
    } opcode_e;

    // Character map kinds
    typedef enum logic [1:0] {
        KIND_DENSE_FULL  = 2'd0,
        KIND_SPARSE_FULL = 2'd1,
        KIND_DENSE_TINY  = 2'd2,
        KIND_SPARSE_TINY = 2'd3
    } map_kind_e;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAP_COUNT   = 2'd0,
        CFG_FONT_USABLE = 2'd1,
        CFG_SPARE_2     = 2'd2,
        CFG_SPARE_3     = 2'd3
    } cfg_index_e;

    // Input tdata layout, first member in the highest bits
    typedef struct packed {
        logic [5:0]         pad;
        logic [CP_W-1:0]    code_point;
        logic [VALUE_W-1:0] mem_value;
        logic [ADDR_W-1:0]  mem_address;
        logic               has_offset_list;
        logic               has_code_list;
        logic [BASE_W-1:0]  entry_base;
        logic [TOTAL_W-1:0] entry_total;
        logic [1:0]         map_kind;
        logic [SPAN_W-1:0]  range_span;
        logic [CP_W-1:0]    range_first;
        logic [IDX_W-1:0]   map_index;
    } in_item_t;

    // One stored character map descriptor
    typedef struct packed {
        logic [CP_W-1:0]    first;
        logic [SPAN_W-1:0]  span;
        map_kind_e          kind;
        logic [TOTAL_W-1:0] total;
        logic [BASE_W-1:0]  base;
        logic               has_code;
        logic               has_ofs;
    } desc_t;

    // Shared add/subtract unit request and response
    typedef struct packed {
        logic             sub;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [ALU_W-1:0] res;
        logic             lt;
    } alu_rsp_t;

endpackage

/* rtl/core/gcl_ram.sv */
// ----------------------------------------------------------------------------
// gcl_ram: simple dual-port memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gcl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/gcl_alu.sv */
// ----------------------------------------------------------------------------
// gcl_alu: shared add/subtract unit
// One adder serving every range check, address sum and search step key compare.
// ----------------------------------------------------------------------------
module gcl_alu (
    input  gcl_pkg::alu_req_t req,
    output gcl_pkg::alu_rsp_t rsp
);
    import gcl_pkg::*;

    logic [ALU_W:0]   sum;
    logic [ALU_W-1:0] b_in;

    // a + b, or a - b as a + ~b + 1; no carry out on subtract means a < b
    assign b_in    = req.sub ? ~req.b : req.b;
    assign sum     = {1'b0, req.a} + {1'b0, b_in} + {{ALU_W{1'b0}}, req.sub};
    assign rsp.res = sum[ALU_W-1:0];
    assign rsp.lt  = req.sub & ~sum[ALU_W];

endmodule

/* rtl/core/gcl_seq.sv */
// ----------------------------------------------------------------------------
// gcl_seq: query sequencer
// Walks the maps in order, range checks, probes offset bytes and binary searches
// with one ALU, and holds the result in an output register.
// ----------------------------------------------------------------------------
module gcl_seq #(
    parameter int MAX_MAPS        = 16,
    parameter int CODE_LIST_DEPTH = 4096,
    parameter int OFFSET_DEPTH    = 4096,
    parameter int SLOT_AW         = 4,
    parameter int CL_AW           = 12,
    parameter int OF_AW           = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // item side
    input  logic                          in_valid,
    output logic                          in_ready,
    input  gcl_pkg::opcode_e              in_opcode,
    input  logic [gcl_pkg::CP_W-1:0]      code_point,
    // configuration
    input  logic [gcl_pkg::CNT_W-1:0]     map_count,
    input  logic                          font_usable,
    // descriptor store
    output logic                          desc_rd_en,
    output logic [SLOT_AW-1:0]            desc_rd_addr,
    input  gcl_pkg::desc_t                desc_rd_data,
    // code list memory
    output logic                          code_rd_en,
    output logic [CL_AW-1:0]              code_rd_addr,
    input  logic [gcl_pkg::VALUE_W-1:0]   code_rd_data,
    // offset memory
    output logic                          ofs_rd_en,
    output logic [OF_AW-1:0]              ofs_rd_addr,
    input  logic [7:0]                    ofs_rd_data,
    // result side
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          out_supported,
    output logic [gcl_pkg::MAP_ID_W-1:0]  out_map
);
    import gcl_pkg::*;

    localparam int SLOT_CW = $clog2(MAX_MAPS + 1);

    typedef enum logic [13:0] {
        S_IDLE    = 14'b00000000000001,
        S_DESC_RD = 14'b00000000000010,
        S_REL     = 14'b00000000000100,
        S_SPAN    = 14'b00000000001000,
        S_TOT     = 14'b00000000010000,
        S_OADDR   = 14'b00000000100000,
        S_OWAIT   = 14'b00000001000000,
        S_CMP     = 14'b00000010000000,
        S_MID     = 14'b00000100000000,
        S_ADDR    = 14'b00001000000000,
        S_KEY     = 14'b00010000000000,
        S_FIN     = 14'b00100000000000,
        S_LWAIT   = 14'b01000000000000,
        S_DONE    = 14'b10000000000000
    } state_t;

    state_t               state_reg, state_next;
    logic [SLOT_CW-1:0]   slot_reg, slot_next;
    logic [SLOT_CW-1:0]   limit_reg, limit_next;
    logic [SLOT_CW-1:0]   slot_plus;
    logic [CP_W-1:0]      cp_reg, cp_next;
    logic [CP_W-1:0]      rel_reg, rel_next;
    logic [TOTAL_W-1:0]   lo_reg, lo_next;
    logic [TOTAL_W-1:0]   hi_reg, hi_next;
    logic [TOTAL_W-1:0]   mid_reg, mid_next;
    logic                 hit_reg, hit_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_sup_reg, out_sup_next;
    logic [MAP_ID_W-1:0]  out_map_reg, out_map_next;

    logic                 map_hit;
    logic                 map_miss;
    logic                 code_addr_ok;
    logic                 ofs_addr_ok;
    alu_req_t             alu_req;
    alu_rsp_t             alu_rsp;

    gcl_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    assign slot_plus    = slot_reg + SLOT_CW'(1);
    assign code_addr_ok = (32'(alu_rsp.res) < CODE_LIST_DEPTH);
    assign ofs_addr_ok  = (32'(alu_rsp.res) < OFFSET_DEPTH);
    assign desc_rd_addr = slot_reg[SLOT_AW-1:0];
    assign code_rd_addr = CL_AW'(alu_rsp.res);
    assign ofs_rd_addr  = OF_AW'(alu_rsp.res);
    assign in_ready     = (state_reg == S_IDLE);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        slot_next      = slot_reg;
        limit_next     = limit_reg;
        cp_next        = cp_reg;
        rel_next       = rel_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg;
        out_sup_next   = out_sup_reg;
        out_map_next   = out_map_reg;
        alu_req        = '{sub: 1'b1, a: '0, b: '0};
        desc_rd_en     = 1'b0;
        code_rd_en     = 1'b0;
        ofs_rd_en      = 1'b0;
        map_hit        = 1'b0;
        map_miss       = 1'b0;

        // result register drains when taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_opcode == OP_QUERY)
                begin
                    cp_next    = code_point;
                    slot_next  = '0;
                    hit_next   = 1'b0;
                    limit_next = (32'(map_count) > MAX_MAPS) ? SLOT_CW'(MAX_MAPS)
                                                             : SLOT_CW'(map_count);
                    if (!font_usable || map_count == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_DESC_RD;
                    end
                end
            end
            S_DESC_RD:
            begin
                desc_rd_en = 1'b1;
                state_next = S_REL;
            end
            // rel = code point - range start; below the start misses
            S_REL:
            begin
                alu_req  = '{sub: 1'b1, a: ALU_W'(cp_reg), b: ALU_W'(desc_rd_data.first)};
                rel_next = alu_rsp.res[CP_W-1:0];
                if (alu_rsp.lt)
                begin
                    map_miss = 1'b1;
                end
                else
                begin
                    state_next = S_SPAN;
                end
            end
            // rel must be below the span, then dispatch by kind
            S_SPAN:
            begin
                alu_req = '{sub: 1'b1, a: ALU_W'(rel_reg), b: ALU_W'(desc_rd_data.span)};
                lo_next = '0;
                hi_next = desc_rd_data.total;
                if (!alu_rsp.lt)
                begin
                    map_miss = 1'b1;
                end
                else
                begin
                    case (desc_rd_data.kind)
                        KIND_DENSE_TINY:
                        begin
                            map_hit = 1'b1;
                        end
                        KIND_DENSE_FULL:
                        begin
                            state_next = S_TOT;
                        end
                        KIND_SPARSE_TINY:
                        begin
                            if (desc_rd_data.has_code)
                            begin
                                state_next = S_CMP;
                            end
                            else
                            begin
                                map_miss = 1'b1;
                            end
                        end
                        default:
                        begin
                            if (desc_rd_data.has_code && desc_rd_data.has_ofs)
                            begin
                                state_next = S_CMP;
                            end
                            else
                            begin
                                map_miss = 1'b1;
                            end
                        end
                    endcase
                end
            end
            // dense full: rel within list, first position always present
            S_TOT:
            begin
                alu_req = '{sub: 1'b1, a: ALU_W'(rel_reg), b: ALU_W'(desc_rd_data.total)};
                if (!desc_rd_data.has_ofs || !alu_rsp.lt)
                begin
                    map_miss = 1'b1;
                end
                else if (rel_reg == '0)
                begin
                    map_hit = 1'b1;
                end
                else
                begin
                    state_next = S_OADDR;
                end
            end
            S_OADDR:
            begin
                alu_req = '{sub: 1'b0, a: ALU_W'(desc_rd_data.base), b: ALU_W'(rel_reg)};
                if (ofs_addr_ok)
                begin
                    ofs_rd_en  = 1'b1;
                    state_next = S_OWAIT;
                end
                else
                begin
                    map_miss = 1'b1;
                end
            end
            S_OWAIT:
            begin
                if (ofs_rd_data != '0)
                begin
                    map_hit = 1'b1;
                end
                else
                begin
                    map_miss = 1'b1;
                end
            end
            // binary search: loop while lo < hi
            S_CMP:
            begin
                alu_req = '{sub: 1'b1, a: ALU_W'(lo_reg), b: ALU_W'(hi_reg)};
                if (alu_rsp.lt)
                begin
                    state_next = S_MID;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_MID:
            begin
                alu_req    = '{sub: 1'b0, a: ALU_W'(lo_reg), b: ALU_W'(hi_reg)};
                mid_next   = alu_rsp.res[TOTAL_W:1];
                state_next = S_ADDR;
            end
            S_ADDR:
            begin
                alu_req = '{sub: 1'b0, a: ALU_W'(desc_rd_data.base), b: ALU_W'(mid_reg)};
                if (code_addr_ok)
                begin
                    code_rd_en = 1'b1;
                    state_next = S_KEY;
                end
                else
                begin
                    map_miss = 1'b1;
                end
            end
            S_KEY:
            begin
                alu_req = '{sub: 1'b1, a: ALU_W'(code_rd_data), b: ALU_W'(rel_reg)};
                if (alu_rsp.lt)
                begin
                    lo_next = mid_reg + TOTAL_W'(1);
                end
                else
                begin
                    hi_next = mid_reg;
                end
                state_next = S_CMP;
            end
            // final probe at lo
            S_FIN:
            begin
                alu_req = '{sub: 1'b0, a: ALU_W'(desc_rd_data.base), b: ALU_W'(lo_reg)};
                if (lo_reg != desc_rd_data.total && code_addr_ok)
                begin
                    code_rd_en = 1'b1;
                    state_next = S_LWAIT;
                end
                else
                begin
                    map_miss = 1'b1;
                end
            end
            S_LWAIT:
            begin
                if (code_rd_data == rel_reg[VALUE_W-1:0])
                begin
                    map_hit = 1'b1;
                end
                else
                begin
                    map_miss = 1'b1;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_sup_next   = hit_reg;
                    out_map_next   = hit_reg ? MAP_ID_W'(slot_reg) : '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // per-map outcome
        if (map_hit)
        begin
            hit_next   = 1'b1;
            state_next = S_DONE;
        end
        else if (map_miss)
        begin
            if (slot_plus == limit_reg)
            begin
                state_next = S_DONE;
            end
            else
            begin
                slot_next  = slot_plus;
                state_next = S_DESC_RD;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        slot_reg    <= slot_next;
        limit_reg   <= limit_next;
        cp_reg      <= cp_next;
        rel_reg     <= rel_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        hit_reg     <= hit_next;
        out_sup_reg <= out_sup_next;
        out_map_reg <= out_map_next;
    end

    assign out_valid     = out_valid_reg;
    assign out_supported = out_sup_reg;
    assign out_map       = out_map_reg;

endmodule

/* rtl/core/glyph_coverage_lookup_top.sv */
// ----------------------------------------------------------------------------
// glyph_coverage_lookup_top: font code point coverage lookup
// Usage:
//   s_axis carries items; tuser holds the opcode. Descriptor, code word and
//   offset byte writes are taken and give no result. A query
//   gives one result item on m_axis: supported and the first matching map.
//   cfg writes set map_count (index 0) and font_usable (index 1); cfg_ready
//   is always high; write only while no query is in flight.
// Operation: a query walks maps in order through one shared add/subtract unit.
//   Each map reads its descriptor and range checks it (S_DESC_RD, S_REL,
//   S_SPAN); a dense full map adds S_TOT, S_OADDR and S_OWAIT, and a sparse
//   map repeats S_CMP, S_MID, S_ADDR and S_KEY per binary search step, then
//   ends with S_CMP, S_FIN and S_LWAIT. A probe past the code list ends the
//   search, so a 4096-word list allows at most 13 steps.
// Writes are accepted back to back while no query is in flight; a query
//   blocks input until its result is loaded into the output register.
// Reset clears control state only; memories and descriptors hold garbage
//   until written, and no clearing pass runs.
// If m_axis stalls, one result waits in the output register; writes are
//   still taken, and the next query waits to hand off its result.
// ----------------------------------------------------------------------------
module glyph_coverage_lookup_top #(
    parameter int MAX_MAPS        = gcl_pkg::MAX_MAPS_DEF,
    parameter int CODE_LIST_DEPTH = gcl_pkg::CODE_LIST_DEPTH_DEF,
    parameter int OFFSET_DEPTH    = gcl_pkg::OFFSET_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // input items
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // map_index, range_first, range_span, map_kind, entry_total, entry_base,
    // has_code_list, has_offset_list, mem_address, mem_value, code_point
    input  logic [gcl_pkg::IN_W-1:0]        s_axis_tdata,
    // opcode
    input  logic [1:0]                      s_axis_tuser,
    // result items
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // supported, matching_map
    output logic [gcl_pkg::OUT_W-1:0]       m_axis_tdata,
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [gcl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gcl_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import gcl_pkg::*;

    localparam int SLOT_AW = (MAX_MAPS > 1) ? $clog2(MAX_MAPS) : 1;
    localparam int CL_AW   = $clog2(CODE_LIST_DEPTH);
    localparam int OF_AW   = $clog2(OFFSET_DEPTH);

    in_item_t             item;
    opcode_e              opcode;
    logic                 in_accept;
    logic                 desc_wr;
    logic                 code_wr;
    logic                 ofs_wr;
    desc_t                desc_wr_data;
    logic [CNT_W-1:0]     map_count_reg;
    logic                 font_usable_reg;

    logic                 desc_rd_en;
    logic [SLOT_AW-1:0]   desc_rd_addr;
    logic [$bits(desc_t)-1:0] desc_rd_bits;
    logic                 code_rd_en;
    logic [CL_AW-1:0]     code_rd_addr;
    logic [VALUE_W-1:0]   code_rd_data;
    logic                 ofs_rd_en;
    logic [OF_AW-1:0]     ofs_rd_addr;
    logic [7:0]           ofs_rd_data;
    logic                 out_supported;
    logic [MAP_ID_W-1:0]  out_map;

    assign item      = in_item_t'(s_axis_tdata);
    assign opcode    = opcode_e'(s_axis_tuser);
    assign in_accept = s_axis_tvalid & s_axis_tready;
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_count_reg   <= '0;
            font_usable_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MAP_COUNT:   map_count_reg   <= cfg_data;
                CFG_FONT_USABLE: font_usable_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // Write decode; out-of-range slots and addresses are dropped
    assign desc_wr = in_accept && opcode == OP_WR_DESC && (32'(item.map_index) < MAX_MAPS);
    assign code_wr = in_accept && opcode == OP_WR_CODE
                     && (32'(item.mem_address) < CODE_LIST_DEPTH);
    assign ofs_wr  = in_accept && opcode == OP_WR_OFS
                     && (32'(item.mem_address) < OFFSET_DEPTH);

    assign desc_wr_data = '{first:    item.range_first,
                            span:     item.range_span,
                            kind:     map_kind_e'(item.map_kind),
                            total:    item.entry_total,
                            base:     item.entry_base,
                            has_code: item.has_code_list,
                            has_ofs:  item.has_offset_list};

    // Descriptor store
    gcl_ram #(
        .WIDTH ($bits(desc_t)),
        .DEPTH (MAX_MAPS),
        .AW    (SLOT_AW)
    ) u_desc_ram (
        .clk     (clk),
        .wr_en   (desc_wr),
        .wr_addr (SLOT_AW'(item.map_index)),
        .wr_data (desc_wr_data),
        .rd_en   (desc_rd_en),
        .rd_addr (desc_rd_addr),
        .rd_data (desc_rd_bits)
    );

    // Sorted code list
    gcl_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CODE_LIST_DEPTH),
        .AW    (CL_AW)
    ) u_code_ram (
        .clk     (clk),
        .wr_en   (code_wr),
        .wr_addr (CL_AW'(item.mem_address)),
        .wr_data (item.mem_value),
        .rd_en   (code_rd_en),
        .rd_addr (code_rd_addr),
        .rd_data (code_rd_data)
    );

    // Glyph offset bytes
    gcl_ram #(
        .WIDTH (8),
        .DEPTH (OFFSET_DEPTH),
        .AW    (OF_AW)
    ) u_ofs_ram (
        .clk     (clk),
        .wr_en   (ofs_wr),
        .wr_addr (OF_AW'(item.mem_address)),
        .wr_data (item.mem_value[7:0]),
        .rd_en   (ofs_rd_en),
        .rd_addr (ofs_rd_addr),
        .rd_data (ofs_rd_data)
    );

    // Query sequencer
    gcl_seq #(
        .MAX_MAPS        (MAX_MAPS),
        .CODE_LIST_DEPTH (CODE_LIST_DEPTH),
        .OFFSET_DEPTH    (OFFSET_DEPTH),
        .SLOT_AW         (SLOT_AW),
        .CL_AW           (CL_AW),
        .OF_AW           (OF_AW)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .in_opcode     (opcode),
        .code_point    (item.code_point),
        .map_count     (map_count_reg),
        .font_usable   (font_usable_reg),
        .desc_rd_en    (desc_rd_en),
        .desc_rd_addr  (desc_rd_addr),
        .desc_rd_data  (desc_t'(desc_rd_bits)),
        .code_rd_en    (code_rd_en),
        .code_rd_addr  (code_rd_addr),
        .code_rd_data  (code_rd_data),
        .ofs_rd_en     (ofs_rd_en),
        .ofs_rd_addr   (ofs_rd_addr),
        .ofs_rd_data   (ofs_rd_data),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_supported (out_supported),
        .out_map       (out_map)
    );

    assign m_axis_tdata = {{(OUT_W - MAP_ID_W - 1){1'b0}}, out_map, out_supported};

    // A miss always reports map zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[4:1] == '0))
        else $error("miss result with nonzero map index");

    // An accepted query holds off further input
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_QUERY) |=> !s_axis_tready)
        else $error("input taken while a query is in flight");

    // A result only appears after the sequencer was busy
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without a query in flight");

endmodule

/* dv/glyph_coverage_lookup_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// glyph_coverage_lookup_top_tb: self-checking bench for the coverage lookup
// Loads character maps, code lists and offset bytes over the item stream,
// queries code points and checks every answer against an in-bench predictor
// of the map scan, with random idling and stalls on both stream sides.
// ----------------------------------------------------------------------------
module glyph_coverage_lookup_top_tb;
    import gcl_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int N_MAPS        = MAX_MAPS_DEF;
    localparam int CODE_DEPTH    = CODE_LIST_DEPTH_DEF;
    localparam int OFS_DEPTH     = OFFSET_DEPTH_DEF;
    localparam int TOP_REGION    = 4032;     // prefilled window at the top of memory
    localparam int CP_MAX        = 2097151;
    localparam int U16_MAX       = 65535;
    localparam int SETTLE_CYCLES = 64;
    localparam int STALL_LIMIT   = 20000;
    localparam int MAX_REPORTS   = 20;
    localparam int FONT_PHASES   = 6;
    localparam int PHASE_ITEMS   = 130;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

    // One character map as the predictor sees it
    typedef struct {
        bit [CP_W-1:0]    first;
        bit [SPAN_W-1:0]  span;
        map_kind_e        kind;
        bit [TOTAL_W-1:0] total;
        bit [BASE_W-1:0]  base;
        bit               has_code;
        bit               has_ofs;
        bit               loaded;
    } char_map_t;

    typedef struct packed {
        logic                supported;
        logic [MAP_ID_W-1:0] map_id;
    } coverage_t;

    // DUT ports
    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_W-1:0]       s_axis_tdata;
    logic [1:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_W-1:0]      m_axis_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Predictor state
    char_map_t   font_maps [N_MAPS];
    bit [15:0]   code_words [CODE_DEPTH];
    bit          code_loaded [CODE_DEPTH];
    bit [7:0]    offset_bytes [OFS_DEPTH];
    bit          offset_loaded [OFS_DEPTH];
    bit [CNT_W-1:0] map_count_reg;
    bit          font_usable_reg;
    coverage_t   coverage_expect [$];

    idle_mode_e  idle_mode = IDLE_NONE;
    int unsigned list_cursor = 0;
    int          fail_count = 0;
    int          items_sent = 0;
    int          queries_sent = 0;
    int          reg_writes = 0;
    int          results_seen = 0;
    int          hits_seen = 0;
    int          quiet_cycles = 0;

    glyph_coverage_lookup_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Clock
    always
    begin
        clk = 1'b0;
        #(CLK_HALF);
        clk = 1'b1;
        #(CLK_HALF);
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Binary search of key in the sorted code list; clears clean on a read of
    // a word that was never loaded
    function automatic bit code_search(input int unsigned base, total, key,
                                       inout bit clean);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        int unsigned addr;
        lo = 0;
        hi = total;
        while (lo < hi)
        begin
            mid  = lo + (hi - lo) / 2;
            addr = base + mid;
            if (addr >= CODE_DEPTH)
                return 1'b0;
            if (!code_loaded[addr])
                clean = 1'b0;
            if (code_words[addr] < key)
                lo = mid + 1;
            else
                hi = mid;
        end
        if (lo >= total)
            return 1'b0;
        addr = base + lo;
        if (addr >= CODE_DEPTH)
            return 1'b0;
        if (!code_loaded[addr])
            clean = 1'b0;
        return code_words[addr] == key;
    endfunction

    // Does map slot cover code point cp
    function automatic bit map_matches(input int slot, input bit [CP_W-1:0] cp,
                                       inout bit clean);
        char_map_t   m;
        int unsigned rel;
        int unsigned addr;
        m = font_maps[slot];
        if (!m.loaded)
        begin
            clean = 1'b0;
            return 1'b0;
        end
        if (cp < m.first)
            return 1'b0;
        rel = cp - m.first;
        if (rel >= m.span)
            return 1'b0;
        case (m.kind)
            KIND_DENSE_TINY:
                return 1'b1;
            KIND_DENSE_FULL:
            begin
                if (!m.has_ofs || rel >= m.total)
                    return 1'b0;
                if (rel == 0)
                    return 1'b1;
                addr = m.base + rel;
                if (addr >= OFS_DEPTH)
                    return 1'b0;
                if (!offset_loaded[addr])
                    clean = 1'b0;
                return offset_bytes[addr] != 8'd0;
            end
            KIND_SPARSE_TINY:
                return m.has_code && rel <= U16_MAX &&
                       code_search(m.base, m.total, rel, clean);
            default:
                return m.has_code && m.has_ofs && rel <= U16_MAX &&
                       code_search(m.base, m.total, rel, clean);
        endcase
    endfunction

    // Scan the counted map slots in order; clean tells whether the scan stays on
    // loaded entries only
    function automatic void find_covering_map(input bit [CP_W-1:0] cp,
                                              output coverage_t cov,
                                              output bit clean);
        int unsigned scan_n;
        cov    = '0;
        clean  = 1'b1;
        scan_n = (map_count_reg > N_MAPS) ? N_MAPS : map_count_reg;
        if (!font_usable_reg)
            return;
        for (int i = 0; i < scan_n; i++)
        begin
            if (map_matches(i, cp, clean))
            begin
                cov.supported = 1'b1;
                cov.map_id    = MAP_ID_W'(i);
                return;
            end
        end
    endfunction

    // Update the predictor with one accepted item
    function automatic void apply_item(input opcode_e op, input in_item_t item);
        coverage_t cov;
        bit        clean;
        items_sent++;
        case (op)
            OP_WR_DESC:
            begin
                font_maps[item.map_index].first    = item.range_first;
                font_maps[item.map_index].span     = item.range_span;
                font_maps[item.map_index].kind     = map_kind_e'(item.map_kind);
                font_maps[item.map_index].total    = item.entry_total;
                font_maps[item.map_index].base     = item.entry_base;
                font_maps[item.map_index].has_code = item.has_code_list;
                font_maps[item.map_index].has_ofs  = item.has_offset_list;
                font_maps[item.map_index].loaded   = 1'b1;
            end
            OP_WR_CODE:
            begin
                code_words[item.mem_address]  = item.mem_value;
                code_loaded[item.mem_address] = 1'b1;
            end
            OP_WR_OFS:
            begin
                offset_bytes[item.mem_address]  = item.mem_value[7:0];
                offset_loaded[item.mem_address] = 1'b1;
            end
            default:
            begin
                find_covering_map(item.code_point, cov, clean);
                coverage_expect.push_back(cov);
                queries_sent++;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic int idle_percent(input bit sender);
        case (idle_mode)
            IDLE_SEND: return sender ? 66 : 0;
            IDLE_RECV: return sender ? 0 : 66;
            IDLE_BOTH: return 14;
            default:   return 0;
        endcase
    endfunction

    // All fields random so unused bits toggle too; pad stays zero
    function automatic in_item_t random_item();
        in_item_t it;
        it     = {$urandom, $urandom, $urandom, $urandom};
        it.pad = '0;
        return it;
    endfunction

    // Send one item and update the predictor when it is taken
    task automatic send_item(input opcode_e op, input in_item_t item);
        while ($urandom_range(99) < idle_percent(1'b1))
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= item;
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        apply_item(op, item);
    endtask

    // Register write, only with no query in flight
    task automatic write_reg(input cfg_index_e idx, input bit [CFG_DATA_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (coverage_expect.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        reg_writes++;
        case (idx)
            CFG_MAP_COUNT:   map_count_reg   = value;
            CFG_FONT_USABLE: font_usable_reg = value[0];
            default: ;
        endcase
    endtask

    task automatic write_map(input int slot, input bit [CP_W-1:0] first,
                             input bit [SPAN_W-1:0] span, input map_kind_e kind,
                             input bit [TOTAL_W-1:0] total, input bit [BASE_W-1:0] base,
                             input bit has_code, input bit has_ofs);
        in_item_t it;
        it                 = random_item();
        it.map_index       = IDX_W'(slot);
        it.range_first     = first;
        it.range_span      = span;
        it.map_kind        = kind;
        it.entry_total     = total;
        it.entry_base      = base;
        it.has_code_list   = has_code;
        it.has_offset_list = has_ofs;
        send_item(OP_WR_DESC, it);
    endtask

    task automatic write_mem(input opcode_e op, input int unsigned addr,
                             input bit [VALUE_W-1:0] value);
        in_item_t it;
        it             = random_item();
        it.mem_address = ADDR_W'(addr);
        it.mem_value   = value;
        send_item(op, it);
    endtask

    // Query cp unless the scan would read an entry never loaded
    task automatic query(input bit [CP_W-1:0] cp);
        in_item_t  it;
        coverage_t cov;
        bit        clean;
        find_covering_map(cp, cov, clean);
        if (clean)
        begin
            it            = random_item();
            it.code_point = cp;
            send_item(OP_QUERY, it);
        end
    endtask

    // Load one map's list and descriptor in a realistic shape
    task automatic build_map(input int slot, input bit [CP_W-1:0] hot_first);
        char_map_t   m;
        int unsigned n;
        int unsigned step;
        int unsigned word;
        bit          sparse;
        m.kind = map_kind_e'($urandom_range(3));
        sparse = (m.kind == KIND_SPARSE_TINY || m.kind == KIND_SPARSE_FULL);
        if ($urandom_range(9) == 0)
        begin
            m.first = CP_W'($urandom_range(CP_MAX));
            m.span  = SPAN_W'($urandom_range(U16_MAX));
        end
        else
        begin
            m.first = CP_W'(hot_first + $urandom_range(600));
            m.span  = SPAN_W'($urandom_range(700, 1));
        end
        if ($urandom_range(7) == 0)
        begin
            // list in the prefilled top window, any length, may run off the end
            m.base  = BASE_W'($urandom_range(CODE_DEPTH - 1, TOP_REGION));
            m.total = TOTAL_W'($urandom_range(U16_MAX));
        end
        else
        begin
            n = ($urandom_range(7) == 0) ? $urandom_range(40) : $urandom_range(12);
            if (list_cursor + n > TOP_REGION)
                list_cursor = 0;
            m.base  = BASE_W'(list_cursor);
            m.total = TOTAL_W'(n);
            list_cursor += n;
            step = m.span / (n + 1) + 1;
            word = $urandom_range(step - 1);
            for (int k = 0; k < n; k++)
            begin
                if (sparse)
                begin
                    write_mem(OP_WR_CODE, m.base + k, word[15:0]);
                    word += $urandom_range(step, 1);
                end
                else if (m.kind == KIND_DENSE_FULL)
                begin
                    write_mem(OP_WR_OFS, m.base + k,
                              ($urandom_range(3) == 0) ? 16'(($urandom & 32'hFF00))
                                                       : 16'($urandom_range(U16_MAX, 1)));
                end
            end
        end
        // flags usually fit the kind, sometimes one or both are wrong
        m.has_code = sparse ^ ($urandom_range(9) == 0);
        m.has_ofs  = (m.kind == KIND_DENSE_FULL || m.kind == KIND_SPARSE_FULL) ^
                     ($urandom_range(9) == 0);
        write_map(slot, m.first, m.span, m.kind, m.total, m.base, m.has_code, m.has_ofs);
    endtask

    // Pick a code point, usually aimed at one of the scanned maps
    task automatic random_query();
        int unsigned scan_n;
        int unsigned slot;
        int unsigned k;
        int unsigned addr;
        char_map_t   m;
        bit [CP_W-1:0] cp;
        scan_n = (map_count_reg > N_MAPS) ? N_MAPS : map_count_reg;
        slot   = (scan_n == 0) ? $urandom_range(N_MAPS - 1) : $urandom_range(scan_n - 1);
        m      = font_maps[slot];
        cp     = CP_W'($urandom_range(CP_MAX));
        case ($urandom_range(9)) inside
            [0:3]:
            begin
                if ((m.kind == KIND_SPARSE_TINY || m.kind == KIND_SPARSE_FULL) &&
                    m.total != 0)
                begin
                    k    = $urandom_range(((m.total > 64) ? 64 : m.total) - 1);
                    addr = m.base + k;
                    if (addr < CODE_DEPTH && code_loaded[addr])
                        cp = CP_W'(m.first + code_words[addr]);
                    else
                        cp = CP_W'(m.first + $urandom_range(m.span));
                end
                else if (m.kind == KIND_DENSE_FULL)
                    cp = CP_W'(m.first + $urandom_range(m.total));
                else
                    cp = CP_W'(m.first + $urandom_range(m.span));
            end
            [4:6]:
                cp = CP_W'(m.first + $urandom_range(m.span + 1));
            [7:8]:
            begin
                case ($urandom_range(3))
                    0:       cp = CP_W'(m.first - 1);
                    1:       cp = m.first;
                    2:       cp = CP_W'(m.first + m.span - 1);
                    default: cp = CP_W'(m.first + m.span);
                endcase
            end
            default: ;
        endcase
        query(cp);
    endtask

    // Stray writes with every field random
    task automatic random_noise();
        in_item_t it;
        it = random_item();
        case ($urandom_range(2))
            0:       send_item(OP_WR_DESC, it);
            1:       send_item(OP_WR_CODE, it);
            default: send_item(OP_WR_OFS, it);
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Hand-built maps hitting each kind and each edge of the lookup
    task automatic test_directed_lookup();
        idle_mode = IDLE_NONE;
        write_reg(CFG_MAP_COUNT, 5'd6);
        write_reg(CFG_FONT_USABLE, 5'd1);
        write_mem(OP_WR_CODE, 4094, 16'd5);
        write_mem(OP_WR_CODE, 4095, 16'd65534);
        write_mem(OP_WR_OFS, 4093, 16'h0011);
        write_mem(OP_WR_OFS, 4094, 16'hFF00);     // low byte zero: offset absent
        write_mem(OP_WR_OFS, 4095, 16'h0001);
        write_map(0, 21'h1FFFFF, 16'd1, KIND_DENSE_TINY, 16'd0, 12'd0, 1'b0, 1'b0);
        write_map(1, 21'h000100, 16'd10, KIND_DENSE_FULL, 16'd4, 12'd4093, 1'b0, 1'b1);
        write_map(2, 21'h001000, 16'hFFFF, KIND_SPARSE_TINY, 16'd2, 12'd4094, 1'b1, 1'b0);
        write_map(3, 21'h030000, 16'd16, KIND_SPARSE_FULL, 16'd2, 12'd4094, 1'b1, 1'b0);
        write_map(4, 21'h030000, 16'd16, KIND_SPARSE_FULL, 16'd2, 12'd4094, 1'b1, 1'b1);
        write_map(5, 21'h040000, 16'd100, KIND_SPARSE_TINY, 16'd3, 12'd4095, 1'b1, 1'b0);
        query(21'h1FFFFF);  // top code point, tiny dense map
        query(21'h000000);  // below every range
        query(21'h000100);  // dense full, first position
        query(21'h000101);  // dense full, zero offset
        query(21'h000102);  // dense full, nonzero offset
        query(21'h000103);  // dense full, offset read past memory
        query(21'h000104);  // dense full, past list length
        query(21'h001005);  // sparse hit, first list word
        query(21'h010FFE);  // sparse hit, largest relative code
        query(21'h001006);  // sparse miss
        query(21'h030005);  // sparse full missing offsets, next map matches
        query(21'h040001);  // search probe past memory
    endtask

    // Whole random fonts under each register setting and idling mode
    task automatic test_random_fonts();
        int          phase_count [FONT_PHASES] = '{16, 31, 1, 16, 9, 16};
        bit          phase_usable [FONT_PHASES] = '{1, 1, 1, 0, 1, 1};
        bit [CP_W-1:0] hot_first;
        // top window holds a sorted code list and mixed offset bytes
        for (int a = TOP_REGION; a < CODE_DEPTH; a++)
        begin
            write_mem(OP_WR_CODE, a, 16'((a - TOP_REGION) * 64 + $urandom_range(63)));
            write_mem(OP_WR_OFS, a, ($urandom_range(2) == 0) ? 16'd0 : 16'($urandom));
        end
        for (int p = 0; p < FONT_PHASES; p++)
        begin
            idle_mode = idle_mode_e'(p % 4);
            write_reg(CFG_MAP_COUNT, CFG_DATA_W'(phase_count[p]));
            write_reg(CFG_FONT_USABLE, CFG_DATA_W'(phase_usable[p]));
            hot_first = CP_W'($urandom_range(CP_MAX - 2000));
            for (int s = 0; s < N_MAPS; s++)
                build_map(s, hot_first);
            repeat (PHASE_ITEMS)
            begin
                if ($urandom_range(9) == 0)
                    random_noise();
                else
                    random_query();
            end
        end
    endtask

    // Empty scan, disabled font and oversized map count on the last font
    task automatic test_register_extremes();
        int settings_count [3] = '{0, 31, 20};
        bit settings_usable [3] = '{1, 0, 1};
        idle_mode = IDLE_BOTH;
        for (int i = 0; i < 3; i++)
        begin
            write_reg(CFG_MAP_COUNT, CFG_DATA_W'(settings_count[i]));
            write_reg(CFG_FONT_USABLE, CFG_DATA_W'(settings_usable[i]));
            repeat (12) random_query();
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: stalls, checking, watchdog
    // ------------------------------------------------------------------------

    always @(posedge clk)
        m_axis_tready <= !($urandom_range(99) < idle_percent(1'b0));

    always @(posedge clk)
    begin : check_result
        coverage_t got;
        coverage_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.supported = m_axis_tdata[0];
            got.map_id    = m_axis_tdata[MAP_ID_W:1];
            results_seen++;
            if (coverage_expect.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t: result with nothing expected, got supported %0b map %0d",
                             $time, got.supported, got.map_id);
            end
            else
            begin
                want = coverage_expect.pop_front();
                if (want.supported)
                    hits_seen++;
                if (got.supported !== want.supported)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: supported expected %0b got %0b",
                                 $time, want.supported, got.supported);
                end
                if (got.map_id !== want.map_id)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: matching_map expected %0d got %0d",
                                 $time, want.map_id, got.map_id);
                end
            end
        end
    end

    // Ends the run when no handshake happens for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready) || !rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, coverage_expect.size());
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_WR_DESC;
        m_axis_tready <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= CFG_MAP_COUNT;
        cfg_data      <= '0;
        map_count_reg   = '0;
        font_usable_reg = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_lookup();
        test_random_fonts();
        test_register_extremes();

        // drain
        s_axis_tvalid <= 1'b0;
        while (coverage_expect.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered: %0d items, %0d register writes, all map kinds, list overruns,",
                 items_sent, reg_writes);
        $display("  %0d queries checked (%0d supported), %0d results seen, %0d errors",
                 queries_sent, hits_seen, results_seen, fail_count);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
